[sv/assert_macros.svh]
// assertion macros shared by the list engine modules
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: check failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("%m: forbidden condition");
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

[sv/bcle_pkg.sv]
// shared types and constants of the bounded circular list engine
// no dependencies; used by bcle_slots and bounded_circular_list_engine
package bcle_pkg;

	localparam int DEPTH  = 64;
	localparam int SLOT_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

	typedef enum logic [2:0] {
		REQ_APPEND  = 3'd0,
		REQ_PREPEND = 3'd1,
		REQ_INSERT  = 3'd2,
		REQ_RM_HEAD = 3'd3,
		REQ_RM_TAIL = 3'd4,
		REQ_READ    = 3'd5
	} req_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_LINK_NEW,
		S_LINK_PRED,
		S_RM_HEAD,
		S_RM_TAIL,
		S_READ,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              take;
		logic              give;
		logic [SLOT_W-1:0] give_slot;
	} slot_req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] first;
		logic [DEPTH-1:0]  map;
	} slot_rsp_t;

endpackage

[sv/bcle_slots.sv]
// free slot map with lowest-free-slot allocation
// depends on bcle_pkg and assert_macros.svh
`include "assert_macros.svh"

module bcle_slots (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bcle_pkg::slot_req_t  req,
	output bcle_pkg::slot_rsp_t  rsp
);

	logic [bcle_pkg::DEPTH-1:0]  free_q;
	logic [bcle_pkg::SLOT_W-1:0] first;

	always_comb begin
		first = '0;
		for (int i = bcle_pkg::DEPTH - 1; i >= 0; i--) begin
			if (free_q[i]) begin
				first = bcle_pkg::SLOT_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '1;
		end else begin
			if (req.take) begin
				free_q[first] <= 1'b0;
			end
			if (req.give) begin
				free_q[req.give_slot] <= 1'b1;
			end
		end
	end

	assign rsp.first = first;
	assign rsp.map   = free_q;

	`ASSERT_HOLDS(a_take_has_free, clk, arst_n, req.take |-> (free_q != '0))
	`ASSERT_HOLDS(a_give_was_used, clk, arst_n, req.give |-> !free_q[req.give_slot])

endmodule

[sv/bounded_circular_list_engine.sv]
// bounded circular list engine: linked ring of up to 64 signed values
// one request at a time; append, prepend, end insert: LINK_NEW, LINK_PRED (not if empty),
// DONE; middle insert WALK first; remove head RM_HEAD, DONE; remove tail RM_TAIL, WALK if
// count > 1, DONE; full, empty, bad position DONE; READ one result per cycle if not stalled
// reset: control state and free map cleared at once; list memories not cleared
// depends on bcle_pkg, bcle_slots and assert_macros.svh
`include "assert_macros.svh"

module bounded_circular_list_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         req_type,
	input  logic [6:0]         position,
	input  logic signed [31:0] item_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] out_value,
	output logic               last,
	output logic [1:0]         status,
	output logic [6:0]         entry_count
);

	localparam int SW = bcle_pkg::SLOT_W;
	localparam int CW = bcle_pkg::CNT_W;

	bcle_pkg::state_t  state_q, state_d;
	bcle_pkg::status_t st_q, st_d;

	logic [SW-1:0] head_q, head_d, tail_q, tail_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [SW-1:0] cur_q, cur_d, rem_q, rem_d, idx_q, idx_d;
	logic [SW-1:0] new_q, new_d, pred_q, pred_d, lnk_new_q, lnk_new_d;
	logic          walk_rm_q, walk_rm_d;
	logic signed [31:0] val_q, val_d;

	// list memories
	logic signed [31:0] ent_mem [bcle_pkg::DEPTH];
	logic [SW-1:0]      lnk_mem [bcle_pkg::DEPTH];
	logic signed [31:0] ent_rd_q;
	logic [SW-1:0]      lnk_rd_q;
	logic [SW-1:0]      rd_addr, ent_wa, lnk_wa, lnk_wd;
	logic               ent_we, lnk_we;

	// output register
	logic               out_valid_q, out_last_q, out_load, out_free, out_last_d;
	logic signed [31:0] out_val_q, out_val_d;
	bcle_pkg::status_t  out_st_q, out_st_d;
	logic [CW-1:0]      out_cnt_q;

	bcle_pkg::slot_req_t slot_req;
	bcle_pkg::slot_rsp_t slot_rsp;

	bcle_slots u_slots (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (slot_req),
		.rsp    (slot_rsp)
	);

	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[ent_wa] <= item_value;
		end
		ent_rd_q <= ent_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (lnk_we) begin
			lnk_mem[lnk_wa] <= lnk_wd;
		end
		lnk_rd_q <= lnk_mem[rd_addr];
	end

	always_comb begin
		state_d   = state_q;
		st_d      = st_q;
		head_d    = head_q;
		tail_d    = tail_q;
		cnt_d     = cnt_q;
		cur_d     = cur_q;
		rem_d     = rem_q;
		idx_d     = idx_q;
		new_d     = new_q;
		pred_d    = pred_q;
		lnk_new_d = lnk_new_q;
		walk_rm_d = walk_rm_q;
		val_d     = val_q;
		rd_addr   = cur_q;
		ent_we    = 1'b0;
		ent_wa    = slot_rsp.first;
		lnk_we    = 1'b0;
		lnk_wa    = new_q;
		lnk_wd    = lnk_new_q;
		slot_req  = '{take: 1'b0, give: 1'b0, give_slot: tail_q};
		out_free  = !out_valid_q || out_ready;
		out_load  = 1'b0;
		out_val_d = val_q;
		out_st_d  = st_q;
		out_last_d = 1'b1;
		in_ready  = (state_q == bcle_pkg::S_IDLE);
		case (state_q)
			bcle_pkg::S_IDLE: begin
				rd_addr = (req_type == bcle_pkg::REQ_RM_TAIL) ? tail_q : head_q;
				cur_d = head_q;
				idx_d = '0;
				val_d = '0;
				st_d  = bcle_pkg::ST_OK;
				if (in_valid) begin
					case (req_type)
						bcle_pkg::REQ_APPEND, bcle_pkg::REQ_PREPEND, bcle_pkg::REQ_INSERT: begin
							if (cnt_q == bcle_pkg::DEPTH_CNT) begin
								st_d    = bcle_pkg::ST_FULL;
								state_d = bcle_pkg::S_DONE;
							end else if (req_type == bcle_pkg::REQ_INSERT && position > cnt_q) begin
								st_d    = bcle_pkg::ST_BADPOS;
								state_d = bcle_pkg::S_DONE;
							end else begin
								ent_we        = 1'b1;
								slot_req.take = 1'b1;
								new_d         = slot_rsp.first;
								cnt_d         = cnt_q + CW'(1);
								lnk_new_d     = head_q;
								pred_d        = tail_q;
								state_d       = bcle_pkg::S_LINK_NEW;
								if (cnt_q == '0) begin
									lnk_new_d = slot_rsp.first;
									head_d    = slot_rsp.first;
									tail_d    = slot_rsp.first;
								end else if (req_type == bcle_pkg::REQ_PREPEND ||
									(req_type == bcle_pkg::REQ_INSERT && position == '0)) begin
									head_d = slot_rsp.first;
								end else if (req_type == bcle_pkg::REQ_APPEND || position == cnt_q) begin
									tail_d = slot_rsp.first;
								end else begin
									rem_d     = SW'(position - CW'(1));
									walk_rm_d = 1'b0;
									state_d   = bcle_pkg::S_WALK;
								end
							end
						end
						bcle_pkg::REQ_RM_HEAD: begin
							if (cnt_q == '0) begin
								st_d    = bcle_pkg::ST_EMPTY;
								state_d = bcle_pkg::S_DONE;
							end else begin
								state_d = bcle_pkg::S_RM_HEAD;
							end
						end
						bcle_pkg::REQ_RM_TAIL: begin
							if (cnt_q == '0) begin
								st_d    = bcle_pkg::ST_EMPTY;
								state_d = bcle_pkg::S_DONE;
							end else begin
								state_d = bcle_pkg::S_RM_TAIL;
							end
						end
						bcle_pkg::REQ_READ: begin
							if (cnt_q == '0) begin
								st_d    = bcle_pkg::ST_EMPTY;
								state_d = bcle_pkg::S_DONE;
							end else begin
								state_d = bcle_pkg::S_READ;
							end
						end
						default: begin
							state_d = bcle_pkg::S_IDLE;
						end
					endcase
				end
			end
			bcle_pkg::S_WALK: begin
				if (rem_q == '0) begin
					pred_d = cur_q;
					if (walk_rm_q) begin
						lnk_we  = 1'b1;
						lnk_wa  = cur_q;
						lnk_wd  = head_q;
						tail_d  = cur_q;
						state_d = bcle_pkg::S_DONE;
					end else begin
						lnk_new_d = lnk_rd_q;
						state_d   = bcle_pkg::S_LINK_NEW;
					end
				end else begin
					cur_d   = lnk_rd_q;
					rd_addr = lnk_rd_q;
					rem_d   = rem_q - SW'(1);
				end
			end
			bcle_pkg::S_LINK_NEW: begin
				lnk_we  = 1'b1;
				lnk_wa  = new_q;
				lnk_wd  = lnk_new_q;
				state_d = (cnt_q == CW'(1)) ? bcle_pkg::S_DONE : bcle_pkg::S_LINK_PRED;
			end
			bcle_pkg::S_LINK_PRED: begin
				lnk_we  = 1'b1;
				lnk_wa  = pred_q;
				lnk_wd  = new_q;
				state_d = bcle_pkg::S_DONE;
			end
			bcle_pkg::S_RM_HEAD: begin
				val_d              = ent_rd_q;
				slot_req.give      = 1'b1;
				slot_req.give_slot = head_q;
				cnt_d              = cnt_q - CW'(1);
				if (cnt_q > CW'(1)) begin
					head_d = lnk_rd_q;
					lnk_we = 1'b1;
					lnk_wa = tail_q;
					lnk_wd = lnk_rd_q;
				end else begin
					head_d = '0;
					tail_d = '0;
				end
				state_d = bcle_pkg::S_DONE;
			end
			bcle_pkg::S_RM_TAIL: begin
				val_d              = ent_rd_q;
				slot_req.give      = 1'b1;
				slot_req.give_slot = tail_q;
				cnt_d              = cnt_q - CW'(1);
				if (cnt_q > CW'(1)) begin
					cur_d     = head_q;
					rd_addr   = head_q;
					rem_d     = SW'(cnt_q - CW'(2));
					walk_rm_d = 1'b1;
					state_d   = bcle_pkg::S_WALK;
				end else begin
					head_d  = '0;
					tail_d  = '0;
					state_d = bcle_pkg::S_DONE;
				end
			end
			bcle_pkg::S_READ: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_val_d  = ent_rd_q;
					out_st_d   = bcle_pkg::ST_OK;
					out_last_d = ({1'b0, idx_q} + CW'(1)) == cnt_q;
					cur_d      = lnk_rd_q;
					rd_addr    = lnk_rd_q;
					idx_d      = idx_q + SW'(1);
					if (out_last_d) begin
						state_d = bcle_pkg::S_IDLE;
					end
				end
			end
			bcle_pkg::S_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = bcle_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bcle_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bcle_pkg::S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			cnt_q   <= cnt_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		st_q      <= st_d;
		cur_q     <= cur_d;
		rem_q     <= rem_d;
		idx_q     <= idx_d;
		new_q     <= new_d;
		pred_q    <= pred_d;
		lnk_new_q <= lnk_new_d;
		walk_rm_q <= walk_rm_d;
		val_q     <= val_d;
		if (out_load) begin
			out_val_q  <= out_val_d;
			out_st_q   <= out_st_d;
			out_last_q <= out_last_d;
			out_cnt_q  <= cnt_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_value   = out_val_q;
	assign last        = out_last_q;
	assign status      = out_st_q;
	assign entry_count = out_cnt_q;

	`ASSERT_NEVER(a_cnt_bound, clk, arst_n, cnt_q > bcle_pkg::DEPTH_CNT)
	`ASSERT_HOLDS(a_free_cnt, clk, arst_n, ($countones(slot_rsp.map) + int'(cnt_q)) == bcle_pkg::DEPTH)
	`ASSERT_HOLDS(a_err_last, clk, arst_n, (out_valid_q && out_st_q != bcle_pkg::ST_OK) |-> out_last_q)
	`ASSERT_HOLDS(a_read_nonempty, clk, arst_n, (state_q == bcle_pkg::S_READ) |-> (cnt_q != '0))

endmodule
